FILE: src/pic_pkg.sv
// Package for the pairwise intersection counter.
// Holds sizes, payload structs, state codes and shared helpers.
// No dependencies.
`default_nettype none
package pic_pkg;

    localparam int MAX_LISTS    = 8;
    localparam int MAX_LIST_LEN = 1024;

    localparam int LIST_W   = 3;
    localparam int NUM_W    = 4;
    localparam int HASH_W   = 64;
    localparam int COUNT_W  = 11;
    localparam int COUNT_MAX = 2047;
    localparam int LEN_W    = $clog2(MAX_LIST_LEN + 1);
    localparam int DEPTH    = MAX_LISTS * MAX_LIST_LEN;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [NUM_W-1:0] ACTIVE_RESET = NUM_W'(8);

    typedef struct packed {
        logic              mode;
        logic [LIST_W-1:0] list_id;
        logic [HASH_W-1:0] hash_value;
    } in_item_t;

    typedef struct packed {
        logic [LIST_W-1:0]  row_list;
        logic [LIST_W-1:0]  col_list;
        logic [COUNT_W-1:0] shared_count;
        logic               last_entry;
        logic               append_dropped;
    } out_item_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [HASH_W-1:0] wdata;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
    } ram_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN_A,
        ST_LEN_B,
        ST_READ,
        ST_CMP,
        ST_EMIT
    } state_t;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_RUN    = 1'b1;

    // Base address of a list plus a position inside it
    function automatic logic [ADDR_W-1:0] list_addr(input logic [LIST_W-1:0] id,
                                                    input logic [LEN_W-1:0] pos);
        logic [ADDR_W+LEN_W-1:0] a;
        a = (ADDR_W+LEN_W)'(id) * (ADDR_W+LEN_W)'(MAX_LIST_LEN) + (ADDR_W+LEN_W)'(pos);
        return a[ADDR_W-1:0];
    endfunction

    // Clamp a list length to the count field
    function automatic logic [COUNT_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [COUNT_W-1:0] r;
        if ((LEN_W + COUNT_W)'(len) > (LEN_W + COUNT_W)'(COUNT_MAX)) begin
            r = COUNT_W'(COUNT_MAX);
        end else begin
            r = COUNT_W'(len);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

FILE: src/pairwise_intersection_counter.sv
// Top level of the pairwise intersection counter.
// Uses pic_pkg, pic_ram and pic_ctrl.
//
// Usage:
//   s_ channel (valid/ready) takes items. mode 0 appends hash_value to list
//   list_id; the value is dropped and a sticky flag set when the list is
//   full, inactive, or the value is not above its last value. Appends
//   stream at one per cycle while no run is in progress.
//   mode 1 runs the merge: for each of the active_lists^2 matrix entries in
//   row-major order the block walks both lists in the hash memory, each
//   comparison taking a registered memory read state and then a compare
//   state; diagonal and empty-list entries skip the walk. The run is done in
//   one pass of the two-read-port hash memory per off-diagonal entry.
//   Results leave through an output register on the m_ channel; when the
//   receiver stalls the walk holds before loading the next entry. The final
//   entry carries last_entry and the run then empties all lists and the flag.
//   Reset (aresetn low, synchronous) empties all lists, clears the flag and
//   sets active_lists to 8. Memory contents need no clearing.
//   APB register 0 at address 0: active_lists (4 bits).
`default_nettype none
module pairwise_intersection_counter (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire pic_pkg::in_item_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output pic_pkg::out_item_t      m_data
);

    logic [pic_pkg::NUM_W-1:0]  active_reg;
    pic_pkg::ram_req_t          ram_req;
    logic [pic_pkg::HASH_W-1:0] rd_a, rd_b;

    // Register write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= pic_pkg::ACTIVE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            active_reg <= pwdata[pic_pkg::NUM_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {{(32 - pic_pkg::NUM_W){1'b0}}, active_reg} : 32'd0;

    pic_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .active_n (active_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .ram_req  (ram_req),
        .rd_a     (rd_a),
        .rd_b     (rd_b)
    );

    pic_ram #(
        .DATA_W (pic_pkg::HASH_W),
        .ADDR_W (pic_pkg::ADDR_W),
        .DEPTH  (pic_pkg::DEPTH)
    ) u_hash_ram (
        .aclk    (aclk),
        .we      (ram_req.we),
        .waddr   (ram_req.waddr),
        .wdata   (ram_req.wdata),
        .raddr_a (ram_req.raddr_a),
        .raddr_b (ram_req.raddr_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

endmodule
`default_nettype wire

FILE: src/pic_ram.sv
// Generic simple RAM: one write port, two registered read ports.
// No dependencies.
`default_nettype none
module pic_ram #(
    parameter int DATA_W = 64,
    parameter int ADDR_W = 13,
    parameter int DEPTH  = 8192
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic [ADDR_W-1:0] raddr_a,
    input  wire logic [ADDR_W-1:0] raddr_b,
    output logic      [DATA_W-1:0] rdata_a,
    output logic      [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write, then register both reads
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

FILE: src/pic_ctrl.sv
// Control for the pairwise intersection counter: append checks, list
// lengths, pair merge walk and result register. Uses pic_pkg.
`default_nettype none
module pic_ctrl (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic [pic_pkg::NUM_W-1:0] active_n,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire pic_pkg::in_item_t         s_data,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output pic_pkg::out_item_t             m_data,
    output pic_pkg::ram_req_t              ram_req,
    input  wire logic [pic_pkg::HASH_W-1:0] rd_a,
    input  wire logic [pic_pkg::HASH_W-1:0] rd_b
);

    pic_pkg::state_t state_reg, state_next;

    logic [pic_pkg::LEN_W-1:0]   len_reg  [pic_pkg::MAX_LISTS];
    logic [pic_pkg::LEN_W-1:0]   len_next [pic_pkg::MAX_LISTS];
    logic [pic_pkg::HASH_W-1:0]  last_reg [pic_pkg::MAX_LISTS];
    logic                        drop_reg, drop_next;
    logic [pic_pkg::LIST_W-1:0]  row_reg, row_next, col_reg, col_next;
    logic [pic_pkg::LEN_W-1:0]   ia_reg, ia_next, ib_reg, ib_next;
    logic [pic_pkg::LEN_W-1:0]   la_reg, la_next;
    logic [pic_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic                        m_valid_reg, m_valid_next;
    pic_pkg::out_item_t          m_data_reg, m_data_next;

    logic [pic_pkg::LIST_W-1:0]  len_sel;
    logic [pic_pkg::LEN_W-1:0]   len_rd;
    logic [pic_pkg::HASH_W-1:0]  last_rd;
    logic                        s_fire, app_ok, slot_free, at_last, col_end;
    logic [pic_pkg::NUM_W-1:0]   n_eff, n_m1;

    // Clamp the active list count
    always_comb begin
        if (active_n == '0) begin
            n_eff = pic_pkg::NUM_W'(1);
        end else if (active_n > pic_pkg::NUM_W'(pic_pkg::MAX_LISTS)) begin
            n_eff = pic_pkg::NUM_W'(pic_pkg::MAX_LISTS);
        end else begin
            n_eff = active_n;
        end
        n_m1 = n_eff - pic_pkg::NUM_W'(1);
    end

    // One length read port: append list, row list, then column list
    always_comb begin
        case (state_reg)
            pic_pkg::ST_IDLE:  len_sel = s_data.list_id;
            pic_pkg::ST_LEN_A: len_sel = row_reg;
            default:           len_sel = col_reg;
        endcase
    end
    assign len_rd  = len_reg[len_sel];
    assign last_rd = last_reg[s_data.list_id];

    assign s_ready   = (state_reg == pic_pkg::ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;
    assign col_end   = ({1'b0, col_reg} == n_m1);
    assign at_last   = col_end && ({1'b0, row_reg} == n_m1);
    assign app_ok    = ({1'b0, s_data.list_id} < n_eff)
                       && (len_rd < pic_pkg::LEN_W'(pic_pkg::MAX_LIST_LEN))
                       && ((len_rd == '0) || (s_data.hash_value > last_rd));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pic_pkg::ST_IDLE: begin
                if (s_fire && s_data.mode == pic_pkg::MODE_RUN) begin
                    state_next = pic_pkg::ST_LEN_A;
                end
            end
            pic_pkg::ST_LEN_A: state_next = pic_pkg::ST_LEN_B;
            pic_pkg::ST_LEN_B: begin
                if (row_reg == col_reg || la_reg == '0 || len_rd == '0) begin
                    state_next = pic_pkg::ST_EMIT;
                end else begin
                    state_next = pic_pkg::ST_READ;
                end
            end
            pic_pkg::ST_READ: state_next = pic_pkg::ST_CMP;
            pic_pkg::ST_CMP: begin
                if (ia_next >= la_reg || ib_next >= len_rd) begin
                    state_next = pic_pkg::ST_EMIT;
                end else begin
                    state_next = pic_pkg::ST_READ;
                end
            end
            pic_pkg::ST_EMIT: begin
                if (slot_free) begin
                    state_next = at_last ? pic_pkg::ST_IDLE : pic_pkg::ST_LEN_A;
                end
            end
            default: state_next = pic_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        len_next     = len_reg;
        drop_next    = drop_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        ia_next      = ia_reg;
        ib_next      = ib_reg;
        la_next      = la_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        ram_req.we      = 1'b0;
        ram_req.waddr   = pic_pkg::list_addr(s_data.list_id, len_rd);
        ram_req.wdata   = s_data.hash_value;
        ram_req.raddr_a = pic_pkg::list_addr(row_reg, ia_reg);
        ram_req.raddr_b = pic_pkg::list_addr(col_reg, ib_reg);
        case (state_reg)
            pic_pkg::ST_IDLE: begin
                if (s_fire && s_data.mode == pic_pkg::MODE_APPEND) begin
                    if (app_ok) begin
                        ram_req.we = 1'b1;
                        len_next[s_data.list_id] = len_rd + pic_pkg::LEN_W'(1);
                    end else begin
                        drop_next = 1'b1;
                    end
                end else if (s_fire) begin
                    row_next = '0;
                    col_next = '0;
                end
            end
            pic_pkg::ST_LEN_A: begin
                la_next  = len_rd;
                ia_next  = '0;
                ib_next  = '0;
                cnt_next = '0;
            end
            pic_pkg::ST_LEN_B: begin
                if (row_reg == col_reg) begin
                    cnt_next = pic_pkg::sat_len(la_reg);
                end
            end
            pic_pkg::ST_CMP: begin
                if (rd_a < rd_b) begin
                    ia_next = ia_reg + pic_pkg::LEN_W'(1);
                end else if (rd_a > rd_b) begin
                    ib_next = ib_reg + pic_pkg::LEN_W'(1);
                end else begin
                    ia_next = ia_reg + pic_pkg::LEN_W'(1);
                    ib_next = ib_reg + pic_pkg::LEN_W'(1);
                    if (cnt_reg != pic_pkg::COUNT_W'(pic_pkg::COUNT_MAX)) begin
                        cnt_next = cnt_reg + pic_pkg::COUNT_W'(1);
                    end
                end
            end
            pic_pkg::ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next                = 1'b1;
                    m_data_next.row_list        = row_reg;
                    m_data_next.col_list        = col_reg;
                    m_data_next.shared_count    = cnt_reg;
                    m_data_next.last_entry      = at_last;
                    m_data_next.append_dropped  = drop_reg;
                    if (at_last) begin
                        // Empty every list and drop the flag
                        for (int k = 0; k < pic_pkg::MAX_LISTS; k++) begin
                            len_next[k] = '0;
                        end
                        drop_next = 1'b0;
                    end else if (col_end) begin
                        col_next = '0;
                        row_next = row_reg + pic_pkg::LIST_W'(1);
                    end else begin
                        col_next = col_reg + pic_pkg::LIST_W'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pic_pkg::ST_IDLE;
            drop_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < pic_pkg::MAX_LISTS; k++) begin
                len_reg[k] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            drop_reg    <= drop_next;
            m_valid_reg <= m_valid_next;
            len_reg     <= len_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        row_reg    <= row_next;
        col_reg    <= col_next;
        ia_reg     <= ia_next;
        ib_reg     <= ib_next;
        la_reg     <= la_next;
        cnt_reg    <= cnt_next;
        m_data_reg <= m_data_next;
        if (ram_req.we) begin
            last_reg[s_data.list_id] <= s_data.hash_value;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

FILE: src/pic_checker.sv
// Port-level checks for the pairwise intersection counter.
// Uses pic_pkg; bound to pairwise_intersection_counter.
`default_nettype none
module pic_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               pready,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire pic_pkg::out_item_t m_data
);

    // Hold a stalled result
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // No new item while a run is still producing entries
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last_entry |-> !s_ready)
        else $error("input taken during a run");

    // The final entry sits on the diagonal
    a_last_diag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.last_entry |-> m_data.row_list == m_data.col_list)
        else $error("final entry off the diagonal");

    // Register port never waits
    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready low");

endmodule

bind pairwise_intersection_counter pic_checker u_pic_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .pready  (pready),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
